// ----- hw/rtl/fmt_pkg.sv -----
// Shared constants and types for the truncating single-precision multiplier.
package fmt_pkg;
    localparam int FRAC_BITS = 23;
    localparam int WORD_BITS = 32;
    localparam logic [7:0] EXP_MAX = 8'hFF;
    localparam logic [31:0] INF_BITS = 32'h7F80_0000;
    localparam logic [31:0] QUIET_MASK = 32'h0040_0000;
    localparam logic [31:0] DEFAULT_NAN = 32'h7FC0_0000;

    typedef logic [31:0] word_t;

    // Operands captured by the input register.
    typedef struct packed {
        word_t a;
        word_t b;
    } operands_t;
endpackage

// ----- hw/rtl/fmt_core.sv -----
// Combinational multiply core: special cases, significand product, normalize, pack.
module fmt_core
    import fmt_pkg::*;
(
    input  operands_t ops,
    output word_t     product
);
    logic [7:0]  ex, ey;
    logic        sgn;
    logic [30:0] ax, ay;
    logic [23:0] mx, my;
    logic [47:0] m;
    logic [31:0] hi;
    logic [9:0]  e;
    logic [10:0] sh;
    logic        special;
    word_t       norm;

    always_comb begin
        ex  = ops.a[30:23];
        ey  = ops.b[30:23];
        sgn = ops.a[31] ^ ops.b[31];
        ax  = ops.a[30:0];
        ay  = ops.b[30:0];
        special = (ex == 8'd0) || (ex == EXP_MAX) || (ey == 8'd0) || (ey == EXP_MAX);
        // A denormal operand keeps only the implicit one.
        mx = {1'b1, (ex == 8'd0) ? 23'd0 : ops.a[22:0]};
        my = {1'b1, (ey == 8'd0) ? 23'd0 : ops.b[22:0]};
        m  = 48'(mx) * 48'(my);
        // Signed biased exponent in ten bits; range is -127..384.
        e  = 10'(ex) + 10'(ey) - 10'd127 + 10'(m[47]);
        hi = m[47] ? {8'd0, m[47:24]} : {8'd0, m[46:23]};
        sh = 11'sd1 - {e[9], e};
        if (!e[9] && (e >= 10'd255)) begin
            norm = INF_BITS | {sgn, 31'd0};
        end else if (e[9] || (e == 10'd0)) begin
            norm = ((sh >= 11'd32) ? 32'd0 : (hi >> sh[4:0])) | {sgn, 31'd0};
        end else begin
            norm = {sgn, e[7:0], hi[22:0]};
        end
        if (special && (ax > INF_BITS[30:0])) begin
            product = ops.a | QUIET_MASK;
        end else if (special && (ay > INF_BITS[30:0])) begin
            product = ops.b | QUIET_MASK;
        end else if (special && (ax == INF_BITS[30:0])) begin
            product = (ay != 31'd0) ? (INF_BITS | {sgn, 31'd0}) : DEFAULT_NAN;
        end else if (special && (ay == INF_BITS[30:0])) begin
            product = (ax != 31'd0) ? (INF_BITS | {sgn, 31'd0}) : DEFAULT_NAN;
        end else if (special && ((ax == 31'd0) || (ay == 31'd0))) begin
            product = {sgn, 31'd0};
        end else begin
            product = norm;
        end
    end
endmodule

// ----- hw/rtl/fp32_multiply_truncate.sv -----
// Top level of the truncating single-precision multiplier with stream ports.
// Usage:
//   s_axis carries one operand pair per transaction: tdata[31:0] is operand_a,
//   tdata[63:32] is operand_b. m_axis returns the product in tdata[31:0].
//   Each transaction passes an input register, one combinational pass through
//   the multiply core, and an output register. The product reaches
//   m_axis_tvalid through the input register and then the output register.
//   Throughput is one transaction per cycle while the receiver does not
//   stall: the whole computation is one combinational pass, and both
//   registers can load in every cycle. When the receiver stalls, the output
//   register holds its data and the input register fills; s_axis_tready drops
//   only when both are full and m_axis_tready is low.
//   A synchronous active-low aresetn empties both registers.
module fp32_multiply_truncate
    import fmt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // operand_a [31:0], operand_b [63:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // product [31:0]
);
    operands_t in_reg;
    logic      in_valid_reg;
    word_t     out_reg;
    logic      out_valid_reg;
    word_t     prod;
    logic      out_load;

    fmt_core u_core (.ops(in_reg), .product(prod));

    assign out_load      = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || out_load;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (s_axis_tready && s_axis_tvalid) begin
            in_reg <= '{a: s_axis_tdata[31:0], b: s_axis_tdata[63:32]};
        end
        if (out_load) begin
            out_reg <= prod;
        end
    end
endmodule
